### design/ght_pkg.sv
// Shared types, constants and helpers for the generational handle table.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package ght_pkg;

    // table geometry
    localparam int SLOT_COUNT = 64;
    localparam int GEN_WIDTH  = 32;
    localparam int IDX_W      = $clog2(SLOT_COUNT);

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [GEN_WIDTH-1:0] gen_t;
    typedef logic [SLOT_COUNT-1:0] slot_vec_t;

    localparam gen_t GEN_ONE = gen_t'(1);

    // request codes
    typedef enum logic [2:0] {
        OP_RESERVE = 3'd0,
        OP_RELEASE = 3'd1,
        OP_COMMIT  = 3'd2,
        OP_DESTROY = 3'd3,
        OP_LOOKUP  = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    // response codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_REFUSED = 2'd2
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP_RD,
        S_SWEEP_WR,
        S_CLEAR_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic sweep_rd;
        logic sweep_wr;
        logic finish;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_clear;
        logic out_free;
        logic sweep_last;
    } stat_t;

    // advance a generation, wrapping past zero to one
    function automatic gen_t next_gen(input gen_t g);
        gen_t n;
        n = g + GEN_ONE;
        return (n == '0) ? GEN_ONE : n;
    endfunction

endpackage

### design/ght_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on ght_pkg for the field types.
`timescale 1ns / 1ps

interface ght_req_if;
    logic          valid;
    logic          ready;
    logic [2:0]    operation;
    ght_pkg::idx_t slot_index;
    ght_pkg::gen_t handle_generation;

    modport source (output valid, output operation, output slot_index,
                    output handle_generation, input ready);
    modport sink   (input valid, input operation, input slot_index,
                    input handle_generation, output ready);
endinterface

### design/ght_rsp_if.sv
// Response channel: valid/ready handshake carrying one response word.
// Depends on ght_pkg for the field types.
`timescale 1ns / 1ps

interface ght_rsp_if;
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    ght_pkg::idx_t result_index;
    ght_pkg::gen_t result_generation;

    modport source (output valid, output status, output result_index,
                    output result_generation, input ready);
    modport sink   (input valid, input status, input result_index,
                    input result_generation, output ready);
endinterface

### design/ght_ctrl.sv
// Controller state machine of the handle table: sequences request load,
// execution and the clear-all sweep. Depends on ght_pkg.
`timescale 1ns / 1ps

module ght_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ght_pkg::stat_t  stat,
    output ght_pkg::cmd_t   cmd
);
    import ght_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.in_clear ? S_SWEEP_RD : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWEEP_RD:
            begin
                state_next = S_SWEEP_WR;
            end
            S_SWEEP_WR:
            begin
                state_next = stat.sweep_last ? S_CLEAR_DONE : S_SWEEP_RD;
            end
            S_CLEAR_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = stat.out_free;
            end
            S_SWEEP_RD:
            begin
                cmd.sweep_rd = 1'b1;
            end
            S_SWEEP_WR:
            begin
                cmd.sweep_wr = 1'b1;
            end
            S_CLEAR_DONE:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/ght_dpath.sv
// Datapath of the handle table: slot marks, generation memory with
// per-entry valid bits, free-slot encoder and response register. Depends on ght_pkg.
`timescale 1ns / 1ps

module ght_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  ght_pkg::cmd_t      cmd,
    output ght_pkg::stat_t     stat,
    input  logic [2:0]         in_operation,
    input  ght_pkg::idx_t      in_slot_index,
    input  ght_pkg::gen_t      in_handle_generation,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output ght_pkg::idx_t      out_result_index,
    output ght_pkg::gen_t      out_result_generation
);
    import ght_pkg::*;

    // generation memory, entry invalid reads as one
    gen_t gen_mem [SLOT_COUNT];

    slot_vec_t occ_reg,  occ_next;
    slot_vec_t res_reg,  res_next;
    slot_vec_t gval_reg, gval_next;
    logic      out_valid_reg, out_valid_next;
    idx_t      sweep_cnt_reg, sweep_cnt_next;

    // request word and lookahead, held while the request runs
    logic [2:0] op_reg;
    idx_t       idx_reg;
    gen_t       hgen_reg;
    logic       free_any_reg;
    idx_t       free_idx_reg;
    gen_t       clr_gen_reg;

    // memory read side
    gen_t rdata_reg;
    logic rd_valid_reg;

    // response register
    logic [1:0] status_reg;
    idx_t       rindex_reg;
    gen_t       rgen_reg;

    slot_vec_t free_vec;
    logic      free_any;
    idx_t      free_idx;
    logic      rd_en;
    idx_t      rd_addr;
    logic      wr_en;
    idx_t      wr_addr;
    gen_t      wr_data;
    gen_t      gen_cur;
    gen_t      gen_adv;
    logic      match;
    logic      cur_occ;
    logic      cur_res;
    logic      can_free;
    logic      can_kill;
    status_t   ex_status;
    idx_t      ex_index;
    gen_t      ex_gen;
    logic      out_load;

    // lowest free slot
    always_comb
    begin
        free_vec = ~(occ_reg | res_reg);
        free_any = |free_vec;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_idx = idx_t'(i);
            end
        end
    end

    // current generation and handle check
    always_comb
    begin
        gen_cur  = rd_valid_reg ? rdata_reg : GEN_ONE;
        gen_adv  = next_gen(gen_cur);
        cur_occ  = occ_reg[idx_reg];
        cur_res  = res_reg[idx_reg];
        match    = (hgen_reg != '0) && (gen_cur == hgen_reg);
        can_free = match && cur_res && !cur_occ;
        can_kill = match && cur_occ && !cur_res;
    end

    // read address
    always_comb
    begin
        rd_en   = cmd.load | cmd.sweep_rd;
        rd_addr = sweep_cnt_reg;
        if (cmd.load)
        begin
            rd_addr = (in_operation == OP_RESERVE) ? free_idx : in_slot_index;
        end
    end

    // request execution and mark updates
    always_comb
    begin
        occ_next       = occ_reg;
        res_next       = res_reg;
        gval_next      = gval_reg;
        sweep_cnt_next = sweep_cnt_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = gen_adv;
        ex_status      = ST_REFUSED;
        ex_index       = idx_reg;
        ex_gen         = gen_cur;

        if (cmd.load && (in_operation == OP_CLEAR))
        begin
            occ_next       = '0;
            res_next       = '0;
            sweep_cnt_next = '0;
        end

        if (cmd.exec)
        begin
            case (op_reg)
                OP_RESERVE:
                begin
                    if (free_any_reg)
                    begin
                        res_next[free_idx_reg] = 1'b1;
                        ex_status = ST_OK;
                        ex_index  = free_idx_reg;
                    end
                    else
                    begin
                        ex_status = ST_FULL;
                        ex_index  = '0;
                        ex_gen    = '0;
                    end
                end
                OP_RELEASE:
                begin
                    if (can_free)
                    begin
                        res_next[idx_reg] = 1'b0;
                        wr_en     = 1'b1;
                        ex_status = ST_OK;
                        ex_gen    = gen_adv;
                    end
                end
                OP_COMMIT:
                begin
                    if (can_free)
                    begin
                        occ_next[idx_reg] = 1'b1;
                        res_next[idx_reg] = 1'b0;
                        ex_status = ST_OK;
                    end
                end
                OP_DESTROY:
                begin
                    if (can_kill)
                    begin
                        occ_next[idx_reg] = 1'b0;
                        res_next[idx_reg] = 1'b0;
                        wr_en     = 1'b1;
                        ex_status = ST_OK;
                        ex_gen    = gen_adv;
                    end
                end
                OP_LOOKUP:
                begin
                    if (can_kill)
                    begin
                        ex_status = ST_OK;
                    end
                end
                default:
                begin
                    ex_status = ST_REFUSED;
                end
            endcase
        end

        // clear-all sweep, write back one advanced entry
        if (cmd.sweep_wr)
        begin
            wr_en          = 1'b1;
            wr_addr        = sweep_cnt_reg;
            sweep_cnt_next = sweep_cnt_reg + idx_t'(1);
        end

        if (wr_en)
        begin
            gval_next[wr_addr] = 1'b1;
        end
    end

    // response register handshake
    always_comb
    begin
        stat.out_free   = !out_valid_reg || out_ready;
        stat.in_clear   = (in_operation == OP_CLEAR);
        stat.sweep_last = (sweep_cnt_reg == idx_t'(SLOT_COUNT - 1));
        out_load        = cmd.exec | cmd.finish;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            res_reg       <= '0;
            gval_reg      <= '0;
            out_valid_reg <= 1'b0;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            occ_reg       <= occ_next;
            res_reg       <= res_next;
            gval_reg      <= gval_next;
            out_valid_reg <= out_valid_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // generation memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gen_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg    <= gen_mem[rd_addr];
            rd_valid_reg <= gval_reg[rd_addr];
        end
    end

    // request word capture and response payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= in_operation;
            idx_reg      <= in_slot_index;
            hgen_reg     <= in_handle_generation;
            free_any_reg <= free_any;
            free_idx_reg <= free_idx;
        end
        if (cmd.sweep_wr && (sweep_cnt_reg == idx_reg))
        begin
            clr_gen_reg <= gen_adv;
        end
        if (cmd.exec)
        begin
            status_reg <= ex_status;
            rindex_reg <= ex_index;
            rgen_reg   <= ex_gen;
        end
        else if (cmd.finish)
        begin
            status_reg <= ST_OK;
            rindex_reg <= idx_reg;
            rgen_reg   <= clr_gen_reg;
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_status            = status_reg;
    assign out_result_index      = rindex_reg;
    assign out_result_generation = rgen_reg;

endmodule

### design/generational_handle_table.sv
// Generational handle table: 64 slots with occupied/reserved marks and 32-bit generations.
// Each request's generation memory read is registered, then its response is loaded,
// waiting while an earlier response is unaccepted; clear-all first sweeps every slot,
// reading it and writing it back advanced. A new request is taken only when idle.
// Reset: all marks clear and every generation reads as 1 through per-slot valid bits.
// Depends on ght_pkg, ght_req_if, ght_rsp_if, ght_ctrl and ght_dpath.
`timescale 1ns / 1ps

module generational_handle_table (
    input  logic     clk,
    input  logic     rst_n,
    ght_req_if.sink  req,
    ght_rsp_if.source rsp
);
    import ght_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencing
    ght_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot state and response word
    ght_dpath u_dpath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .stat                  (stat),
        .in_operation          (req.operation),
        .in_slot_index         (req.slot_index),
        .in_handle_generation  (req.handle_generation),
        .out_valid             (rsp.valid),
        .out_ready             (rsp.ready),
        .out_status            (rsp.status),
        .out_result_index      (rsp.result_index),
        .out_result_generation (rsp.result_generation)
    );

endmodule

### test/ght_reply_checker.sv
// Reply checker for the generational handle table: mirrors the slot table and compares replies.
// Depends on ght_pkg; sits beside the block in tb_generational_handle_table.
`timescale 1ns / 1ps

module ght_reply_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  logic [2:0]    req_operation,
    input  ght_pkg::idx_t req_slot_index,
    input  ght_pkg::gen_t req_handle_generation,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  logic [1:0]    rsp_status,
    input  ght_pkg::idx_t rsp_result_index,
    input  ght_pkg::gen_t rsp_result_generation,
    output int            error_count,
    output int            words_pending
);
    import ght_pkg::*;

    typedef struct packed {
        status_t status;
        idx_t    index;
        gen_t    generation;
    } handle_reply_t;

    // mirrored slot table
    logic          occupied [SLOT_COUNT];
    logic          reserved [SLOT_COUNT];
    gen_t          slot_gen [SLOT_COUNT];
    handle_reply_t expected_replies [$];

    // next generation, wrapping past zero to one
    function automatic gen_t bumped(input gen_t g);
        gen_t n;
        n = g + gen_t'(1);
        return (n == '0) ? gen_t'(1) : n;
    endfunction

    // apply one request word to the mirror and return the reply it should give
    function automatic handle_reply_t apply_request(input logic [2:0] op, input idx_t idx,
                                                    input gen_t hgen);
        handle_reply_t r;
        logic          in_table;
        logic          hit;
        logic          claimed;
        r.status     = ST_REFUSED;
        r.index      = idx;
        r.generation = '0;
        in_table     = (int'(idx) < SLOT_COUNT);
        hit          = in_table && (hgen != '0) && (slot_gen[idx] == hgen);
        claimed      = 1'b0;
        case (op)
            OP_RESERVE:
            begin
                r.status = ST_FULL;
                r.index  = '0;
                // lowest slot neither occupied nor reserved
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!claimed && !occupied[i] && !reserved[i])
                    begin
                        reserved[i]  = 1'b1;
                        claimed      = 1'b1;
                        r.status     = ST_OK;
                        r.index      = idx_t'(i);
                        r.generation = slot_gen[i];
                    end
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    occupied[i] = 1'b0;
                    reserved[i] = 1'b0;
                    slot_gen[i] = bumped(slot_gen[i]);
                end
                r.status = ST_OK;
                if (in_table)
                    r.generation = slot_gen[idx];
            end
            default:
            begin
                if (in_table)
                begin
                    case (op)
                        OP_RELEASE:
                            if (hit && reserved[idx] && !occupied[idx])
                            begin
                                reserved[idx] = 1'b0;
                                slot_gen[idx] = bumped(slot_gen[idx]);
                                r.status      = ST_OK;
                            end
                        OP_COMMIT:
                            if (hit && reserved[idx] && !occupied[idx])
                            begin
                                occupied[idx] = 1'b1;
                                reserved[idx] = 1'b0;
                                r.status      = ST_OK;
                            end
                        OP_DESTROY:
                            if (hit && occupied[idx] && !reserved[idx])
                            begin
                                occupied[idx] = 1'b0;
                                slot_gen[idx] = bumped(slot_gen[idx]);
                                r.status      = ST_OK;
                            end
                        OP_LOOKUP:
                            if (hit && occupied[idx] && !reserved[idx])
                                r.status = ST_OK;
                        default:
                            ;
                    endcase
                    r.generation = slot_gen[idx];
                end
            end
        endcase
        return r;
    endfunction

    // compare replies first: a reply never belongs to a request taken on the same edge
    always @(posedge clk or negedge rst_n)
    begin : reply_tracking
        handle_reply_t want;
        handle_reply_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                occupied[i] = 1'b0;
                reserved[i] = 1'b0;
                slot_gen[i] = gen_t'(1);
            end
            expected_replies.delete();
            error_count   = 0;
            words_pending = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply word with no request outstanding: status %0d index %0d gen %0h",
                           rsp_status, rsp_result_index, rsp_result_generation);
                    error_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp_status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_status);
                        error_count++;
                    end
                    if (rsp_result_index !== want.index)
                    begin
                        $error("result_index: expected %0d, got %0d", want.index,
                               rsp_result_index);
                        error_count++;
                    end
                    if (rsp_result_generation !== want.generation)
                    begin
                        $error("result_generation: expected %0h, got %0h", want.generation,
                               rsp_result_generation);
                        error_count++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                fresh = apply_request(req_operation, req_slot_index, req_handle_generation);
                expected_replies = {expected_replies, fresh};
            end
            words_pending = expected_replies.size();
        end
    end

endmodule

### test/tb_generational_handle_table.sv
// Top of the generational handle table bench: clock, reset, request stimulus and reply pacing.
// Depends on ght_pkg, ght_req_if, ght_rsp_if, generational_handle_table and ght_reply_checker.
`timescale 1ns / 1ps

module tb_generational_handle_table;
    import ght_pkg::*;

    // request codes the block does not define
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam int RANDOM_WORDS = 1040;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RECENT_DEPTH = 16;

    logic clk = 1'b0;
    logic rst_n;

    ght_req_if req_ch ();
    ght_rsp_if rsp_ch ();

    int   fail_count;
    int   words_pending;
    int   idle_cycles;
    int   rx_hold;
    bit   tx_fast;
    bit   rx_fast;
    gen_t known_gen [SLOT_COUNT];
    idx_t recent_slots [$];

    generational_handle_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ght_reply_checker reply_check (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .req_valid             (req_ch.valid),
        .req_ready             (req_ch.ready),
        .req_operation         (req_ch.operation),
        .req_slot_index        (req_ch.slot_index),
        .req_handle_generation (req_ch.handle_generation),
        .rsp_valid             (rsp_ch.valid),
        .rsp_ready             (rsp_ch.ready),
        .rsp_status            (rsp_ch.status),
        .rsp_result_index      (rsp_ch.result_index),
        .rsp_result_generation (rsp_ch.result_generation),
        .error_count           (fail_count),
        .words_pending         (words_pending)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // reply side: random stall after each word, and learn handles from what comes back
    always @(posedge clk or negedge rst_n)
    begin : rx_pacing
        int n;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_hold      <= 0;
            for (int i = 0; i < SLOT_COUNT; i++)
                known_gen[i] = gen_t'(1);
            recent_slots.delete();
        end
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            n = rx_fast ? 0 : $urandom_range(0, 11);
            rsp_ch.ready <= (n == 0);
            rx_hold      <= n;
            // even a refused reply carries the slot's current generation
            if (rsp_ch.status != ST_FULL)
                known_gen[rsp_ch.result_index] = rsp_ch.result_generation;
            if (rsp_ch.status == ST_OK)
            begin
                recent_slots = {recent_slots, rsp_ch.result_index};
                if (recent_slots.size() > RECENT_DEPTH)
                    recent_slots.pop_front();
            end
        end
        else if (rx_hold > 1)
            rx_hold <= rx_hold - 1;
        else
        begin
            rx_hold      <= 0;
            rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("generational_handle_table test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // present one request word after a random gap and hold it until taken
    task automatic send_word(input logic [2:0] op, input idx_t idx, input gen_t g);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.operation         <= op;
        req_ch.slot_index        <= idx;
        req_ch.handle_generation <= g;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // stop sending until every outstanding reply has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    // mostly live handles, with stale, null and arbitrary ones mixed in
    task automatic send_random_word();
        int         pick;
        int         gpick;
        logic [2:0] op;
        idx_t       idx;
        gen_t       g;
        pick = $urandom_range(0, 99);
        if (pick < 32)
            op = OP_RESERVE;
        else if (pick < 50)
            op = OP_COMMIT;
        else if (pick < 63)
            op = OP_DESTROY;
        else if (pick < 73)
            op = OP_RELEASE;
        else if (pick < 92)
            op = OP_LOOKUP;
        else if (pick < 95)
            op = OP_CLEAR;
        else
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        if (recent_slots.size() > 0 && $urandom_range(0, 9) < 7)
            idx = recent_slots[$urandom_range(0, recent_slots.size() - 1)];
        else
            idx = idx_t'($urandom_range(0, SLOT_COUNT - 1));
        gpick = $urandom_range(0, 19);
        if (gpick < 14)
            g = known_gen[idx];
        else if (gpick < 16)
            g = known_gen[idx] - gen_t'(1);
        else if (gpick < 17)
            g = '0;
        else
            g = gen_t'($urandom());
        send_word(op, idx, g);
    endtask

    initial
    begin
        rst_n                    <= 1'b0;
        req_ch.valid             <= 1'b0;
        req_ch.operation         <= OP_LOOKUP;
        req_ch.slot_index        <= '0;
        req_ch.handle_generation <= '0;
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: basic life cycle of two handles
        send_word(OP_RESERVE, 6'd0, '0);
        send_word(OP_RESERVE, 6'd0, '0);
        send_word(OP_COMMIT, 6'd0, 32'd1);
        send_word(OP_LOOKUP, 6'd0, 32'd1);
        // null handle, and lookup of a slot only reserved
        send_word(OP_LOOKUP, 6'd0, '0);
        send_word(OP_LOOKUP, 6'd1, 32'd1);
        // commit twice, release with the wrong generation, then properly, then again
        send_word(OP_COMMIT, 6'd0, 32'd1);
        send_word(OP_RELEASE, 6'd1, 32'd2);
        send_word(OP_RELEASE, 6'd1, 32'd1);
        send_word(OP_RELEASE, 6'd1, 32'd2);
        // destroy, then the same handle again once stale
        send_word(OP_DESTROY, 6'd0, 32'd1);
        send_word(OP_DESTROY, 6'd0, 32'd1);
        // top slot with an all-ones handle, and both undefined codes
        send_word(OP_DESTROY, 6'd63, 32'hFFFF_FFFF);
        send_word(OP_SPARE_A, 6'd5, '0);
        send_word(OP_SPARE_B, 6'd63, 32'h8000_0000);
        // reuse of a freed slot, null destroy, clear with handles live
        send_word(OP_RESERVE, 6'd0, '0);
        send_word(OP_COMMIT, 6'd0, 32'd2);
        send_word(OP_DESTROY, 6'd0, '0);
        send_word(OP_CLEAR, 6'd63, '0);
        send_word(OP_LOOKUP, 6'd0, 32'd3);
        send_word(OP_RESERVE, 6'd0, '0);
        send_word(OP_COMMIT, 6'd2, 32'd1);
        send_word(OP_CLEAR, 6'd0, 32'hFFFF_FFFF);
        wait_drained();

        // random phase, idling styles changed every few dozen words
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 60 == 0)
            begin
                tx_fast = ($urandom_range(0, 3) == 0);
                rx_fast = ($urandom_range(0, 3) == 0);
            end
            if (n % 300 == 150)
                wait_drained();
            // run of reserves, enough to fill the table from empty
            if (n == 400 || n == 900)
                repeat (SLOT_COUNT + 6)
                    send_word(OP_RESERVE, idx_t'($urandom_range(0, SLOT_COUNT - 1)),
                              gen_t'($urandom()));
            send_random_word();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && words_pending == 0)
            $display("generational_handle_table test passed");
        else
            $display("generational_handle_table test failed");
        $finish;
    end

endmodule
